// ===== hw/rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int unsigned IP_W      = 32;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned REM_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd60000;
  localparam logic [TIME_W-1:0] PERIOD_RST   = 32'd10000;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_STORED = 3'd2,
    ST_FULL   = 3'd3,
    ST_DONE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } state_e;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ===== hw/rtl/arpc_cmp_unit.sv =====
`timescale 1ns / 1ps

module arpc_cmp_unit import arpc_pkg::*; (
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  input  logic [TIME_W-1:0] lim_i,
  output cmp_res_t          res_o
);

  logic [TIME_W-1:0] diff;

  // wrapping difference, then limit compare
  assign diff      = a_i - b_i;
  assign res_o.eq  = (a_i == b_i);
  assign res_o.gt  = (diff > lim_i);

endmodule

// ===== hw/rtl/arp_cache_with_aging.sv =====
`timescale 1ns / 1ps

// IPv4-to-MAC cache with ageing. One transaction is taken while start is high
// and busy is low; busy then stays high until the single result appears for
// one cycle with done_o, which the receiver must take as it comes.
// Entries are scanned one per cycle through a single read port of the entry
// memory, with one shared subtract/compare unit: lookup, insert and clear scan
// the slots in order (lookup stops early at the first matching slot, insert at
// the first free or matching slot), and a tick first checks its period and
// scans only when a sweep is due. A result may leave in the same cycle that a
// new transaction is accepted.
module arp_cache_with_aging import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action_i,
  input  logic [IP_W-1:0]      ip_addr_i,
  input  logic [MAC_W-1:0]     mac_addr_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [MAC_W-1:0]     found_mac_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [REM_W-1:0]     removed_count_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [AW:0]   NENT = (AW + 1)'(ENTRIES);

  state_e state_q, state_d;
  action_e act_q;
  logic [IP_W-1:0]   ip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] life_q, period_q;
  logic [TIME_W-1:0] sweep_q, sweep_d;
  logic [ENTRIES-1:0] vld_q, vld_d;
  logic [AW:0]   iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [MAC_W-1:0]    fmac_q, fmac_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [REM_W-1:0]    rem_q, rem_d;

  logic [IP_W-1:0]   ip_mem    [ENTRIES];
  logic [MAC_W-1:0]  mac_mem   [ENTRIES];
  logic [TIME_W-1:0] stamp_mem [ENTRIES];
  logic [IP_W-1:0]   rd_ip_q;
  logic [MAC_W-1:0]  rd_mac_q;
  logic [TIME_W-1:0] rd_stamp_q;
  logic              wr_en, rd_en;

  logic              addr_op;
  logic [TIME_W-1:0] cmp_a, cmp_b, cmp_lim;
  cmp_res_t          cmp;

  assign addr_op = (act_q == ACT_LOOKUP) || (act_q == ACT_INSERT);
  assign cmp_a   = addr_op ? ip_q : now_q;
  assign cmp_b   = (state_q == S_CHECK) ? sweep_q : (addr_op ? rd_ip_q : rd_stamp_q);
  assign cmp_lim = (state_q == S_CHECK) ? period_q : life_q;

  arpc_cmp_unit u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .lim_i (cmp_lim),
    .res_o (cmp)
  );

  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    vld_d    = vld_q;
    iss_d    = iss_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    status_d = status_q;
    fmac_d   = fmac_q;
    slot_d   = slot_q;
    rem_d    = rem_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (action_e'(action_i) == ACT_TICK) ? S_CHECK : S_SCAN;
          iss_d   = '0;
          cnt_d   = '0;
        end
      end
      S_CHECK: begin
        if (cmp.gt) begin
          sweep_d = now_q;
          state_d = S_SCAN;
        end else begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ST_DONE;
          fmac_d   = '0;
          slot_d   = '0;
          rem_d    = '0;
        end
      end
      S_SCAN: begin
        if (iss_q < NENT) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          pidx_d = iss_q[AW-1:0];
          iss_d  = iss_q + (AW + 1)'(1);
        end
        if (pend_q) begin
          case (act_q)
            ACT_LOOKUP: begin
              if (vld_q[pidx_q] && cmp.eq) begin
                state_d  = S_IDLE;
                pend_d   = 1'b0;
                done_d   = 1'b1;
                status_d = ST_HIT;
                fmac_d   = rd_mac_q;
                slot_d   = SLOT_W'(pidx_q);
                rem_d    = '0;
              end else if (pidx_q == LAST) begin
                state_d  = S_IDLE;
                pend_d   = 1'b0;
                done_d   = 1'b1;
                status_d = ST_MISS;
                fmac_d   = '0;
                slot_d   = '0;
                rem_d    = '0;
              end
            end
            ACT_INSERT: begin
              if (!vld_q[pidx_q] || cmp.eq) begin
                wr_en         = 1'b1;
                vld_d[pidx_q] = (ip_q[IP_W-1 -: 8] != 8'd0);
                state_d       = S_IDLE;
                pend_d        = 1'b0;
                done_d        = 1'b1;
                status_d      = ST_STORED;
                fmac_d        = '0;
                slot_d        = SLOT_W'(pidx_q);
                rem_d         = '0;
              end else if (pidx_q == LAST) begin
                state_d  = S_IDLE;
                pend_d   = 1'b0;
                done_d   = 1'b1;
                status_d = ST_FULL;
                fmac_d   = '0;
                slot_d   = '0;
                rem_d    = '0;
              end
            end
            default: begin
              // tick sweep or clear
              if (vld_q[pidx_q] && (act_q == ACT_CLEAR || cmp.gt)) begin
                vld_d[pidx_q] = 1'b0;
                cnt_d         = cnt_q + CW'(1);
              end
              if (pidx_q == LAST) begin
                state_d  = S_IDLE;
                pend_d   = 1'b0;
                done_d   = 1'b1;
                status_d = ST_DONE;
                fmac_d   = '0;
                slot_d   = '0;
                rem_d    = REM_W'(cnt_d);
              end
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      life_q   <= LIFETIME_RST;
      period_q <= PERIOD_RST;
      sweep_q  <= '0;
      vld_q    <= '0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
      pidx_q   <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      vld_q   <= vld_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LIFETIME) begin
          life_q <= cfg_wdata_i;
        end else if (cfg_idx_i == CFG_PERIOD) begin
          period_q <= cfg_wdata_i;
        end
      end
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      act_q <= action_e'(action_i);
      ip_q  <= ip_addr_i;
      mac_q <= mac_addr_i;
      now_q <= now_ms_i;
    end
    status_q <= status_d;
    fmac_q   <= fmac_d;
    slot_q   <= slot_d;
    rem_q    <= rem_d;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ip_mem[pidx_q]    <= ip_q;
      mac_mem[pidx_q]   <= mac_q;
      stamp_mem[pidx_q] <= now_q;
    end
    if (rd_en) begin
      rd_ip_q    <= ip_mem[iss_q[AW-1:0]];
      rd_mac_q   <= mac_mem[iss_q[AW-1:0]];
      rd_stamp_q <= stamp_mem[iss_q[AW-1:0]];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_mac_o     = fmac_q;
  assign slot_o          = slot_q;
  assign removed_count_o = rem_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import arpc_pkg::*;

  localparam int N_SLOTS = 16;
  localparam int POOL    = 24;
  localparam int N_DIR   = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    status_e              status;
    logic [MAC_W-1:0]     mac;
    logic [SLOT_W-1:0]    slot;
    logic [REM_W-1:0]     removed;
  } arp_res_t;

  typedef struct packed {
    action_e              act;
    logic [IP_W-1:0]      ip;
    logic [MAC_W-1:0]     mac;
    logic [TIME_W-1:0]    now;
    logic                 typed;
    arp_res_t             want;
  } dir_row_t;

  localparam arp_res_t NO_EXP = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_q = 1'b0;
  action_e              act_q = ACT_LOOKUP;
  logic [IP_W-1:0]      ip_q = '0;
  logic [MAC_W-1:0]     mac_q = '0;
  logic [TIME_W-1:0]    now_q = '0;
  logic                 typed_q = 1'b0;
  arp_res_t             want_q = '0;
  logic                 cfg_we_q = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_q = '0;
  logic [CFG_W-1:0]     cfg_data_q = '0;

  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  rep_status;
  logic [MAC_W-1:0]     rep_mac;
  logic [SLOT_W-1:0]    rep_slot;
  logic [REM_W-1:0]     rep_removed;

  arp_cache_with_aging dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start_q),
    .busy           (busy),
    .action_i       (act_q),
    .ip_addr_i      (ip_q),
    .mac_addr_i     (mac_q),
    .now_ms_i       (now_q),
    .cfg_we_i       (cfg_we_q),
    .cfg_idx_i      (cfg_idx_q),
    .cfg_wdata_i    (cfg_data_q),
    .done_o         (done),
    .status_o       (rep_status),
    .found_mac_o    (rep_mac),
    .slot_o         (rep_slot),
    .removed_count_o(rep_removed)
  );

  // cache image kept alongside the block
  logic [IP_W-1:0]   m_ip    [N_SLOTS];
  logic [MAC_W-1:0]  m_mac   [N_SLOTS];
  logic [TIME_W-1:0] m_stamp [N_SLOTS];
  logic [TIME_W-1:0] m_last_sweep;
  logic [TIME_W-1:0] m_lifetime;
  logic [TIME_W-1:0] m_period;

  arp_res_t          due_replies [$];
  int                err_cnt = 0;
  int                idle_pct = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [IP_W-1:0]   ip_pool [POOL];
  dir_row_t          dir_tab [N_DIR];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(string what, logic [MAC_W-1:0] got, logic [MAC_W-1:0] want);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic arp_res_t arp_cache_apply(action_e act, logic [IP_W-1:0] ip,
                                               logic [MAC_W-1:0] mac,
                                               logic [TIME_W-1:0] now);
    arp_res_t          r;
    logic              found;
    logic [TIME_W-1:0] age;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_LOOKUP: begin
        r.status = ST_MISS;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!found && m_ip[i][31:24] != 8'h00 && m_ip[i] == ip) begin
            found = 1'b1;
            r.status = ST_HIT;
            r.mac = m_mac[i];
            r.slot = i[SLOT_W-1:0];
          end
        end
      end
      ACT_INSERT: begin
        r.status = ST_FULL;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!found && (m_ip[i] == ip || m_ip[i][31:24] == 8'h00)) begin
            found = 1'b1;
            m_ip[i] = ip;
            m_mac[i] = mac;
            m_stamp[i] = now;
            r.status = ST_STORED;
            r.slot = i[SLOT_W-1:0];
          end
        end
      end
      ACT_TICK: begin
        r.status = ST_DONE;
        age = now - m_last_sweep;
        if (age > m_period) begin
          for (int i = 0; i < N_SLOTS; i++) begin
            age = now - m_stamp[i];
            if (m_ip[i][31:24] != 8'h00 && age > m_lifetime) begin
              m_ip[i] = '0;
              m_mac[i] = '0;
              m_stamp[i] = '0;
              r.removed++;
            end
          end
          m_last_sweep = now;
        end
      end
      default: begin
        r.status = ST_DONE;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (m_ip[i][31:24] != 8'h00) r.removed++;
          m_ip[i] = '0;
          m_mac[i] = '0;
          m_stamp[i] = '0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    arp_res_t want;
    arp_res_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < N_SLOTS; i++) begin
        m_ip[i] = '0;
        m_mac[i] = '0;
        m_stamp[i] = '0;
      end
      m_last_sweep = '0;
      m_lifetime = LIFETIME_RST;
      m_period = PERIOD_RST;
    end else begin
      if (done) begin
        if (due_replies.size() == 0) begin
          report("unrequested result, status", rep_status, '0);
        end else begin
          want = due_replies.pop_front();
          if (rep_status !== want.status) report("status", rep_status, want.status);
          if (rep_mac !== want.mac) report("found_mac", rep_mac, want.mac);
          if (rep_slot !== want.slot) report("slot", rep_slot, want.slot);
          if (rep_removed !== want.removed) report("removed_count", rep_removed, want.removed);
        end
      end
      if (cfg_we_q) begin
        case (cfg_idx_q)
          CFG_LIFETIME: m_lifetime = cfg_data_q;
          CFG_PERIOD:   m_period = cfg_data_q;
          default: ;
        endcase
      end
      if (start_q && !busy) begin
        pred = arp_cache_apply(act_q, ip_q, mac_q, now_q);
        due_replies.push_back(typed_q ? want_q : pred);
      end
    end
  end

  task automatic send_item(action_e act, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                           logic [TIME_W-1:0] now, logic typed, arp_res_t want);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_q <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
    start_q <= 1'b1;
    act_q <= act;
    ip_q <= ip;
    mac_q <= mac;
    now_q <= now;
    typed_q <= typed;
    want_q <= want;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start_q <= 1'b0;
    @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (N_SLOTS + 4) @(posedge clk_i);
  endtask

  // spare indices written last so that aliasing onto a real register shows up
  task automatic set_limits(logic [CFG_W-1:0] life, logic [CFG_W-1:0] per);
    cfg_we_q <= 1'b1;
    cfg_idx_q <= CFG_LIFETIME;
    cfg_data_q <= life;
    @(posedge clk_i);
    cfg_idx_q <= CFG_PERIOD;
    cfg_data_q <= per;
    @(posedge clk_i);
    cfg_idx_q <= CFG_SPARE2;
    cfg_data_q <= $urandom();
    @(posedge clk_i);
    cfg_idx_q <= CFG_SPARE3;
    cfg_data_q <= $urandom();
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
  endtask

  // last few pool addresses have a zero first octet
  task automatic refill_pool();
    for (int j = 0; j < POOL; j++) begin
      ip_pool[j] = $urandom();
      if (j < POOL - 3) begin
        if (ip_pool[j][31:24] == 8'h00) ip_pool[j][31:24] = 8'h01;
      end else begin
        ip_pool[j][31:24] = 8'h00;
      end
    end
  endtask

  task automatic run_random(int n, logic [TIME_W-1:0] step_max);
    int               pick;
    action_e          act;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    refill_pool();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(step_max);
      if (pick < 38) act = ACT_LOOKUP;
      else if (pick < 83) act = ACT_INSERT;
      else if (pick < 98) act = ACT_TICK;
      else act = ACT_CLEAR;
      ip = ($urandom_range(6) == 0) ? $urandom() : ip_pool[$urandom_range(POOL - 1)];
      mac = {16'($urandom()), $urandom()};
      send_item(act, ip, mac, clock_ms, 1'b0, NO_EXP);
    end
  endtask

  initial begin
    dir_tab = '{
      '{ACT_LOOKUP, 32'hC0A8_0001, 48'h0, 32'h0, 1'b1, '{ST_MISS, 48'h0, 4'd0, 5'd0}},
      '{ACT_TICK, 32'h0, 48'h0, 32'h0, 1'b1, '{ST_DONE, 48'h0, 4'd0, 5'd0}},
      '{ACT_CLEAR, 32'h0, 48'h0, 32'h0, 1'b1, '{ST_DONE, 48'h0, 4'd0, 5'd0}},
      '{ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_STORED, 48'h0, 4'd0, 5'd0}},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0, 1'b1,
        '{ST_HIT, 48'hFFFF_FFFF_FFFF, 4'd0, 5'd0}},
      '{ACT_INSERT, 32'h0100_0000, 48'h0, 32'h0, 1'b1, '{ST_STORED, 48'h0, 4'd1, 5'd0}},
      '{ACT_INSERT, 32'h00FF_FFFF, 48'h1234_5678_9ABC, 32'd5, 1'b1,
        '{ST_STORED, 48'h0, 4'd2, 5'd0}},
      '{ACT_LOOKUP, 32'h00FF_FFFF, 48'h0, 32'h0, 1'b1, '{ST_MISS, 48'h0, 4'd0, 5'd0}},
      '{ACT_INSERT, 32'h0A00_0001, 48'hAAAA_BBBB_CCCC, 32'd100, 1'b0, NO_EXP},
      '{ACT_INSERT, 32'hFFFF_FFFF, 48'h0000_0000_0001, 32'd200, 1'b0, NO_EXP},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0, 1'b0, NO_EXP},
      '{ACT_LOOKUP, 32'h0100_0000, 48'h0, 32'h0, 1'b0, NO_EXP},
      '{ACT_LOOKUP, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{ST_MISS, 48'h0, 4'd0, 5'd0}},
      '{ACT_INSERT, 32'h0000_0000, 48'h5555_5555_5555, 32'd300, 1'b0, NO_EXP},
      '{ACT_TICK, 32'h0, 48'h0, 32'd10000, 1'b1, '{ST_DONE, 48'h0, 4'd0, 5'd0}},
      '{ACT_TICK, 32'h0, 48'h0, 32'd10001, 1'b0, NO_EXP},
      '{ACT_TICK, 32'h0, 48'h0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
      '{ACT_INSERT, 32'h0A0B_0C0D, 48'h0102_0304_0506, 32'hFFFF_FF00, 1'b0, NO_EXP},
      '{ACT_TICK, 32'h0, 48'h0, 32'h0001_0000, 1'b0, NO_EXP},
      '{ACT_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 32'h0001_0001, 1'b0, NO_EXP},
      '{ACT_CLEAR, 32'h0, 48'h0, 32'h0, 1'b0, NO_EXP},
      '{ACT_LOOKUP, 32'h8000_0000, 48'h0, 32'h0, 1'b1, '{ST_MISS, 48'h0, 4'd0, 5'd0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      send_item(dir_tab[r].act, dir_tab[r].ip, dir_tab[r].mac, dir_tab[r].now,
                dir_tab[r].typed, dir_tab[r].want);
    end
    drain();

    set_limits(32'd200, 32'd50);
    idle_pct = 6;
    run_random(200, 32'd40);
    drain();

    // zero limits: any ageing entry goes at the next sweep
    set_limits(32'd0, 32'd0);
    idle_pct = 79;
    run_random(200, 32'd3);
    drain();

    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_pct = 0;
    run_random(150, 32'hFFFF_FFFF);
    drain();

    // time runs across the wrap
    set_limits(32'd1000, 32'd100);
    clock_ms = 32'hFFFF_F000;
    run_random(150, 32'd60);
    drain();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_cmp_unit.sv
hw/rtl/arp_cache_with_aging.sv
tb/sv/tb_top.sv
